// ===== hdl/cps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Shared constants for the chunk pad stripper: byte codes, result kinds,
// status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] BYTE_PAD  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_FILL = 8'hF0;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_REFUSED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFUSE     = 1'd1;

endpackage

// ===== hdl/cps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/chunk_pad_stripper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_pad_stripper
// Removes trailing pad bytes from a stream of fixed-size chunks and emits the
// recovered message bytes followed by one status word per message.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while the block is collecting a chunk;
// each data byte is written into a chunk RAM of CHUNK_BYTES-2 entries. On the
// final byte of a chunk the input stalls while the kept bytes are read back
// one at a time: each output byte takes a RAM read and then a hand-off to
// the output register, and output stall holds that hand-off. The input also
// stalls while the status word goes out when a word carries message_end, and
// the length cap can stop a chunk before its kept bytes are all out.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, as the block itself does not enforce this.
module chunk_pad_stripper
    import cps_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_chunk_byte,
    input  logic                 i_message_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic [STAT_W-1:0]    o_status,
    output logic [LEN_W-1:0]     o_count,
    output logic                 o_last
);

    localparam int unsigned DATA_N = CHUNK_BYTES - 2;
    localparam int unsigned POS_W  = $clog2(CHUNK_BYTES);
    localparam int unsigned ADDR_W = $clog2(DATA_N);

    localparam logic [POS_W-1:0] LAST_DATA_POS = POS_W'(CHUNK_BYTES - 3);
    localparam logic [POS_W-1:0] CHECK_POS     = POS_W'(CHUNK_BYTES - 2);
    localparam logic [POS_W-1:0] FINAL_POS     = POS_W'(CHUNK_BYTES - 1);
    localparam logic [POS_W-1:0] FULL_LEN      = POS_W'(DATA_N);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_STAT
    } t_state;

    t_state r_state;

    logic [LEN_W-1:0]  r_max_length;
    logic              r_refuse;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_pad_start;
    logic              r_pad_seen;
    logic [LEN_W-1:0]  r_emitted;
    logic              r_overflowed;
    logic [POS_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_len;
    logic              r_end;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [BYTE_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic [LEN_W-1:0]  r_out_count;
    logic              r_out_last;

    logic              w_accept;
    logic              w_slot;
    logic              w_out_load;
    logic              w_store_we;
    logic [BYTE_W-1:0] w_rdata;
    logic [POS_W-1:0]  w_idx_inc;
    logic [LEN_W:0]    w_emit_inc;
    logic              w_last_byte;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_slot     = !r_out_valid || !i_out_stall;
    assign w_out_load = w_slot && ((r_state == ST_WR) || (r_state == ST_STAT));
    assign w_store_we = w_accept && (r_pos <= LAST_DATA_POS);
    assign w_idx_inc  = r_idx + POS_W'(1);
    assign w_emit_inc = {1'b0, r_emitted} + (LEN_W+1)'(1);
    assign w_last_byte = !r_end
        && ((w_idx_inc == r_len) || (w_emit_inc >= {1'b0, r_max_length}));

    cps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_N)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (i_chunk_byte),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_length <= '1;
            r_refuse     <= 1'b0;
            r_pos        <= '0;
            r_pad_start  <= '0;
            r_pad_seen   <= 1'b0;
            r_emitted    <= '0;
            r_overflowed <= 1'b0;
            r_idx        <= '0;
            r_len        <= '0;
            r_end        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_kind   <= KIND_DATA;
            r_out_data   <= '0;
            r_out_status <= STATUS_OK;
            r_out_count  <= '0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                    CFG_REFUSE:     r_refuse     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_end <= i_message_end;
                        r_idx <= '0;
                        if (r_pos >= FINAL_POS) begin
                            r_len       <= r_pad_seen ? r_pad_start : FULL_LEN;
                            r_pos       <= '0;
                            r_pad_seen  <= 1'b0;
                            r_pad_start <= '0;
                            if (!r_refuse && !r_overflowed
                                && (r_pad_seen ? (r_pad_start != '0) : 1'b1)) begin
                                r_state <= ST_RD;
                            end else if (i_message_end) begin
                                r_state <= ST_STAT;
                            end
                        end else if (i_message_end) begin
                            r_pos       <= '0;
                            r_pad_seen  <= 1'b0;
                            r_pad_start <= '0;
                            r_state     <= ST_STAT;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                            if (r_pos <= LAST_DATA_POS) begin
                                if (i_chunk_byte == BYTE_PAD) begin
                                    r_pad_seen  <= 1'b1;
                                    r_pad_start <= r_pos;
                                end else if (i_chunk_byte != BYTE_FILL) begin
                                    r_pad_seen <= 1'b0;
                                end
                            end else if (r_pos == CHECK_POS) begin
                                if (i_chunk_byte != BYTE_FILL) begin
                                    r_pad_seen <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_RD: begin
                    if (r_emitted >= r_max_length) begin
                        r_overflowed <= 1'b1;
                        r_state      <= r_end ? ST_STAT : ST_IDLE;
                    end else begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (w_slot) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_DATA;
                        r_out_data   <= w_rdata;
                        r_out_status <= STATUS_OK;
                        r_out_count  <= '0;
                        r_out_last   <= w_last_byte;
                        r_emitted    <= w_emit_inc[LEN_W-1:0];
                        r_idx        <= w_idx_inc;
                        if (w_idx_inc == r_len) begin
                            r_state <= r_end ? ST_STAT : ST_IDLE;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_STAT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_STATUS;
                        r_out_data  <= '0;
                        r_out_last  <= 1'b1;
                        if (r_refuse) begin
                            r_out_status <= STATUS_REFUSED;
                            r_out_count  <= '0;
                        end else if (r_overflowed) begin
                            r_out_status <= STATUS_OVERFLOW;
                            r_out_count  <= '0;
                        end else begin
                            r_out_status <= STATUS_OK;
                            r_out_count  <= r_emitted;
                        end
                        r_emitted    <= '0;
                        r_overflowed <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_data_byte = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_STATUS)) |-> r_out_last)
        else $error("status word without last");

    a_bad_status_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_STATUS) && (r_out_status != STATUS_OK))
            |-> (r_out_count == '0))
        else $error("nonzero count on failed status");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) || (r_state == ST_WR)) |-> (r_idx < r_len))
        else $error("chunk read past kept length");

    a_msg_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_STAT) && w_slot) |=> ((r_emitted == '0) && !r_overflowed))
        else $error("message state not cleared after status");
`endif

endmodule

// ===== tb/sv/chunk_pad_stripper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_pad_stripper_tb
// Drives random padded chunk streams into the pad stripper and checks every
// output word against a cycle-free model of the stripping rules.
// ----------------------------------------------------------------------------
// A driver feeds input words from a pending queue with random gaps, and a
// monitor takes output words under random stall. Each accepted input word is
// run through the model, which queues the data and status words it should
// cause. Registers are rewritten between phases once the block has drained:
// length caps of zero, one chunk, just over a chunk and the reset value,
// with and without ciphertext refusal. Chunks are mostly well formed pad
// patterns with random content, plus broken pads, doubled pad markers and
// early message ends that drop a partial chunk.
// ----------------------------------------------------------------------------
module chunk_pad_stripper_tb;
    import cps_pkg::*;

    localparam int unsigned CHUNK_BYTES = 32;
    localparam int unsigned PERIOD_NS   = 8;
    localparam int unsigned SETTLE_CYC  = 4 * CHUNK_BYTES;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 32;
    localparam longint unsigned LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0] chunk_byte;
        logic              message_end;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  count;
        logic              last;
    } t_out_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_chunk_byte = '0;
    logic                 i_message_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_kind;
    logic [BYTE_W-1:0]    o_data_byte;
    logic [STAT_W-1:0]    o_status;
    logic [LEN_W-1:0]     o_count;
    logic                 o_last;

    chunk_pad_stripper #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_chunk_byte(i_chunk_byte),
        .i_message_end(i_message_end),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_data_byte(o_data_byte),
        .o_status(o_status),
        .o_count(o_count),
        .o_last(o_last)
    );

    always #(PERIOD_NS / 2) i_clk = ~i_clk;

    t_in_word  pending_words[$];
    t_out_word stripped_words[$];
    int        queued_total = 0;
    int        mismatch_count = 0;

    // register shadows
    logic [LEN_W-1:0] cap_len = 16'hFFFF;
    logic             refuse_on = 1'b0;

    // message state
    int               cur_pos;
    logic [BYTE_W-1:0] chunk_mem [CHUNK_BYTES-2];
    int               pad_at;
    logic             in_pad;
    logic [LEN_W-1:0] sent_len;
    logic             len_over;

    int   in_gap = 0;
    logic in_calm = 1'b0;
    int   out_hold = 0;
    logic out_calm = 1'b0;

    function automatic void clear_message();
        cur_pos  = 0;
        pad_at   = 0;
        in_pad   = 1'b0;
        sent_len = '0;
        len_over = 1'b0;
    endfunction

    task automatic strip_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        t_out_word made [CHUNK_BYTES];
        int        n;
        int        keep;
        int        i;
        n = 0;
        if (cur_pos <= CHUNK_BYTES - 3) begin
            chunk_mem[cur_pos] = b;
            if (b == BYTE_PAD) begin
                in_pad = 1'b1;
                pad_at = cur_pos;
            end else if (b != BYTE_FILL) begin
                in_pad = 1'b0;
            end
        end else if (cur_pos == CHUNK_BYTES - 2) begin
            if (b != BYTE_FILL) in_pad = 1'b0;
        end
        if (cur_pos >= CHUNK_BYTES - 1) begin
            keep = in_pad ? pad_at : CHUNK_BYTES - 2;
            if (!refuse_on) begin
                i = 0;
                while (i < keep && !len_over) begin
                    if (sent_len >= cap_len) begin
                        len_over = 1'b1;
                    end else begin
                        made[n] = '{KIND_DATA, chunk_mem[i], STATUS_OK, 16'd0, 1'b0};
                        n = n + 1;
                        sent_len = sent_len + 1'b1;
                        i = i + 1;
                    end
                end
            end
            cur_pos = 0;
            in_pad  = 1'b0;
            pad_at  = 0;
        end else begin
            cur_pos = cur_pos + 1;
        end
        if (msg_end) begin
            if (refuse_on)
                made[n] = '{KIND_STATUS, 8'd0, STATUS_REFUSED, 16'd0, 1'b0};
            else if (len_over)
                made[n] = '{KIND_STATUS, 8'd0, STATUS_OVERFLOW, 16'd0, 1'b0};
            else
                made[n] = '{KIND_STATUS, 8'd0, STATUS_OK, sent_len, 1'b0};
            n = n + 1;
            clear_message();
        end
        for (i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            stripped_words.push_back(made[i]);
        end
    endtask

    function automatic string word_text(input t_out_word w);
        return $sformatf("kind=%0d data=%02h status=%0d count=%0d last=%0d",
                         w.kind, w.data_byte, w.status, w.count, w.last);
    endfunction

    task automatic report_mismatch(input string what, input t_out_word got,
                                   input t_out_word want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 40)
            $display("%0t: %s: got %s, want %s",
                     $time, what, word_text(got), word_text(want));
    endtask

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge i_clk) begin : drive_in
        logic     hold;
        t_in_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
            clear_message();
        end else begin
            hold = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                strip_byte(i_chunk_byte, i_message_end);
                hold = 1'b0;
                if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
            end
            if (!hold) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    nxt = pending_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_chunk_byte  <= nxt.chunk_byte;
                    i_message_end <= nxt.message_end;
                    in_gap = pick_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_out_word got;
        t_out_word want;
        int        len;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_kind, o_data_byte, o_status, o_count, o_last};
                if (stripped_words.size() == 0) begin
                    report_mismatch("unexpected word", got, '0);
                end else begin
                    want = stripped_words.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.status !== want.status || got.count !== want.count ||
                        got.last !== want.last)
                        report_mismatch("wrong word", got, want);
                end
            end
            if ($urandom_range(0, 199) == 0) out_calm = ~out_calm;
            if (out_hold > 0) begin
                out_hold = out_hold - 1;
                i_out_stall <= 1'b1;
            end else begin
                len = pick_gap(out_calm);
                if (len > 0) begin
                    out_hold = len - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic msg_end);
        t_in_word w;
        w = '{b, msg_end};
        pending_words.push_back(w);
        queued_total = queued_total + 1;
    endtask

    function automatic logic [BYTE_W-1:0] rnd_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return BYTE_W'($urandom_range(0, 255));
        if (r < 8) return BYTE_PAD;
        return BYTE_FILL;
    endfunction

    // one chunk image, of which the first n_bytes words are queued
    task automatic queue_chunk(input int n_bytes, input logic close_msg);
        logic [BYTE_W-1:0] cb [CHUNK_BYTES];
        int style;
        int p;
        int q;
        int i;
        for (i = 0; i < CHUNK_BYTES; i++) cb[i] = rnd_byte();
        case ($urandom_range(0, 5))
            0: p = 0;
            1: p = CHUNK_BYTES - 3;
            default: p = $urandom_range(0, CHUNK_BYTES - 3);
        endcase
        style = $urandom_range(0, 9);
        if (style != 5 && style != 9) begin
            cb[p] = BYTE_PAD;
            for (i = p + 1; i <= CHUNK_BYTES - 2; i++) cb[i] = BYTE_FILL;
        end
        case (style)
            6: begin
                // broken fill run
                q = $urandom_range(p + 1, CHUNK_BYTES - 2);
                cb[q] = BYTE_W'($urandom_range(0, 255));
                if (cb[q] == BYTE_FILL) cb[q] = 8'h0F;
            end
            7: begin
                // later pad marker wins
                if (p < CHUNK_BYTES - 3) begin
                    q = $urandom_range(p + 1, CHUNK_BYTES - 3);
                    cb[q] = BYTE_PAD;
                end
            end
            8: cb[CHUNK_BYTES - 2] = BYTE_PAD;
            9: begin
                for (i = 0; i <= CHUNK_BYTES - 2; i++)
                    cb[i] = $urandom_range(0, 1) ? BYTE_PAD : BYTE_FILL;
            end
            default: ;
        endcase
        for (i = 0; i < n_bytes; i++) push_word(cb[i], close_msg && i == n_bytes - 1);
    endtask

    task automatic queue_message();
        int r;
        int nfull;
        int c;
        logic early;
        r = $urandom_range(0, 9);
        nfull = (r < 6) ? 1 : (r < 9) ? 2 : 3;
        early = ($urandom_range(0, 4) == 0);
        for (c = 0; c < nfull; c++) queue_chunk(CHUNK_BYTES, !early && c == nfull - 1);
        if (early) queue_chunk($urandom_range(1, CHUNK_BYTES - 1), 1'b1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_MAX_LENGTH) cap_len = val;
        else refuse_on = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || stripped_words.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int ph;
        int start;
        logic [LEN_W-1:0] cap;
        logic             refuse;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message, early ends dropping partial chunks, field extremes
        push_word(8'h00, 1'b1);
        push_word(BYTE_PAD, 1'b0);
        push_word(BYTE_FILL, 1'b0);
        push_word(8'h5A, 1'b1);
        push_word(BYTE_PAD, 1'b1);
        push_word(BYTE_FILL, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hA5, 1'b1);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cap = 16'hFFFF; refuse = 1'b0; end
                1: begin cap = 16'd0; refuse = 1'b0; end
                2: begin cap = LEN_W'(CHUNK_BYTES - 2); refuse = 1'b0; end
                3: begin cap = LEN_W'(CHUNK_BYTES - 1); refuse = 1'b0; end
                4: begin cap = LEN_W'($urandom_range(1, 90)); refuse = 1'b0; end
                5: begin cap = 16'hFFFF; refuse = 1'b1; end
                6: begin cap = 16'd0; refuse = 1'b1; end
                default: begin cap = LEN_W'($urandom_range(0, 65535)); refuse = 1'b0; end
            endcase
            write_reg(CFG_MAX_LENGTH, cap);
            write_reg(CFG_REFUSE, {{(LEN_W-1){1'b0}}, refuse});
            @(negedge i_clk);
            start = queued_total;
            while (queued_total - start < PHASE_WORDS) queue_message();
            wait_drained();
        end

        if (mismatch_count == 0 && stripped_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
